@@ rtl/cfm_pkg.sv @@
// Shared types, constants and reset values for the cell fault counter monitor.
`timescale 1ns / 1ps

package cfm_pkg;

    localparam int NUM_MONITORS      = 4;
    localparam int CELLS_PER_MONITOR = 12;
    localparam int NUM_CELLS         = NUM_MONITORS * CELLS_PER_MONITOR;
    localparam int CELL_IDX_W        = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

    localparam int CNT_W      = 8;
    localparam int VOLT_W     = 16;
    localparam int TEMP_W     = 12;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_SEL_W  = 3;

    // Register indexes on the configuration port (byte address is 4 * index).
    localparam logic [REG_SEL_W-1:0] REG_VOLTAGE_LOW_LIMIT   = 3'd0;
    localparam logic [REG_SEL_W-1:0] REG_VOLTAGE_HIGH_LIMIT  = 3'd1;
    localparam logic [REG_SEL_W-1:0] REG_TEMP_LOW_LIMIT      = 3'd2;
    localparam logic [REG_SEL_W-1:0] REG_TEMP_HIGH_LIMIT     = 3'd3;
    localparam logic [REG_SEL_W-1:0] REG_VOLTAGE_FAULT_COUNT = 3'd4;
    localparam logic [REG_SEL_W-1:0] REG_TEMP_FAULT_COUNT    = 3'd5;

    // Reset values: 3.2 V, 4.18 V, 5.0 C, 58.0 C, three readings each.
    localparam logic [VOLT_W-1:0]        RST_VOLTAGE_LOW_LIMIT   = 16'd32000;
    localparam logic [VOLT_W-1:0]        RST_VOLTAGE_HIGH_LIMIT  = 16'd41800;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_LOW_LIMIT      = 12'sd50;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_HIGH_LIMIT     = 12'sd580;
    localparam logic [CNT_W-1:0]         RST_VOLTAGE_FAULT_COUNT = 8'd3;
    localparam logic [CNT_W-1:0]         RST_TEMP_FAULT_COUNT    = 8'd3;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_VOLT_FAULT = 2'd1,
        STATUS_TEMP_FAULT = 2'd2,
        STATUS_SKIPPED    = 2'd3
    } cell_status_t;

    typedef struct packed {
        logic [VOLT_W-1:0]        voltage_low_limit;
        logic [VOLT_W-1:0]        voltage_high_limit;
        logic signed [TEMP_W-1:0] temp_low_limit;
        logic signed [TEMP_W-1:0] temp_high_limit;
        logic [CNT_W-1:0]         voltage_fault_count;
        logic [CNT_W-1:0]         temp_fault_count;
    } cfg_t;

endpackage

@@ rtl/cfm_in_if.sv @@
// Handshake interface carrying one cell reading word.
`timescale 1ns / 1ps

interface cfm_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        monitor_index;
    logic [3:0]        cell_index;
    logic [15:0]       voltage_code;
    logic              voltage_link_error;
    logic signed [11:0] temperature;
    logic              temperature_link_error;
    logic              scan_last;

    modport source (
        output valid,
        output monitor_index,
        output cell_index,
        output voltage_code,
        output voltage_link_error,
        output temperature,
        output temperature_link_error,
        output scan_last,
        input  ready
    );

    modport sink (
        input  valid,
        input  monitor_index,
        input  cell_index,
        input  voltage_code,
        input  voltage_link_error,
        input  temperature,
        input  temperature_link_error,
        input  scan_last,
        output ready
    );
endinterface

@@ rtl/cfm_out_if.sv @@
// Handshake interface carrying one cell status word.
`timescale 1ns / 1ps

interface cfm_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] cell_status;
    logic       scan_fault;

    modport source (
        output valid,
        output cell_status,
        output scan_fault,
        input  ready
    );

    modport sink (
        input  valid,
        input  cell_status,
        input  scan_fault,
        output ready
    );
endinterface

@@ rtl/cell_fault_counter_monitor_unit.sv @@
// Top level of the cell fault counter monitor: counter store, checks and result register.
`timescale 1ns / 1ps

// Path: an accepted reading word goes through the check stage registers into the result register.
// Throughput: one reading word per cycle; the counter RAM is read on acceptance and
// written back when the word moves into the result register, with a forwarding register
// for a repeated cell. Input ready drops only while a held status word is not taken.
// Reset: limits and fault counts take their default values, scan_halted clears,
// and per-cell valid flags clear so that every counter reads as zero at once.

module cell_fault_counter_monitor_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    cfm_in_if.sink                            reading,
    cfm_out_if.source                         status,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cfm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [cfm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [cfm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import cfm_pkg::*;

    localparam int ENTRY_W = 2 * CNT_W;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             fault;
    } bump_t;

    // One counter step: a good reading clears the counter, a bad one counts up
    // and saturates at the fault count, which raises the fault. Zero acts as one.
    function automatic bump_t bump(input logic [CNT_W-1:0] cnt,
                                   input logic bad,
                                   input logic [CNT_W-1:0] limit);
        bump_t           res;
        logic [CNT_W-1:0] lim;
        logic [CNT_W:0]   inc;
        lim = (limit == '0) ? CNT_W'(1) : limit;
        inc = {1'b0, cnt} + (CNT_W + 1)'(1);
        res.cnt   = '0;
        res.fault = 1'b0;
        if (bad)
        begin
            if (inc >= {1'b0, lim})
            begin
                res.cnt   = lim;
                res.fault = 1'b1;
            end
            else
            begin
                res.cnt = inc[CNT_W-1:0];
            end
        end
        return res;
    endfunction

    cfg_t cfg;

    cfm_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---------------------------------------------------------------
    // Input side: cell address and range check of the incoming word.
    // ---------------------------------------------------------------
    logic                  accept;
    logic                  in_range;
    logic [CELL_IDX_W-1:0] in_idx;

    assign in_range = (int'(reading.monitor_index) < NUM_MONITORS) &&
                      (int'(reading.cell_index) < CELLS_PER_MONITOR);

    // An out-of-range word reads entry zero; its data is never used.
    always_comb
    begin
        in_idx = '0;
        if (in_range)
        begin
            in_idx = CELL_IDX_W'(reading.monitor_index) * CELL_IDX_W'(CELLS_PER_MONITOR)
                   + CELL_IDX_W'(reading.cell_index);
        end
    end

    // ---------------------------------------------------------------
    // Check stage registers. The RAM read data lines up with these.
    // ---------------------------------------------------------------
    logic                     s1_valid_reg;
    logic                     s1_in_range_reg;
    logic [CELL_IDX_W-1:0]    s1_idx_reg;
    logic [VOLT_W-1:0]        s1_voltage_reg;
    logic                     s1_vlink_reg;
    logic signed [TEMP_W-1:0] s1_temp_reg;
    logic                     s1_tlink_reg;
    logic                     s1_last_reg;

    logic                     out_valid_reg;
    cell_status_t             out_status_reg;
    logic                     out_scan_fault_reg;

    logic                     s1_fire;

    assign s1_fire       = s1_valid_reg && (!out_valid_reg || status.ready);
    assign reading.ready = !s1_valid_reg || s1_fire;
    assign accept        = reading.valid && reading.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_in_range_reg <= in_range;
            s1_idx_reg      <= in_idx;
            s1_voltage_reg  <= reading.voltage_code;
            s1_vlink_reg    <= reading.voltage_link_error;
            s1_temp_reg     <= reading.temperature;
            s1_tlink_reg    <= reading.temperature_link_error;
            s1_last_reg     <= reading.scan_last;
        end
    end

    // ---------------------------------------------------------------
    // Counter store: voltage counter in the upper byte, temperature
    // counter in the lower byte. Entries that were never written since
    // reset read as zero through their valid flags.
    // ---------------------------------------------------------------
    logic                  ram_we;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic [NUM_CELLS-1:0]  cnt_valid_reg;

    cfm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_CELLS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_idx_reg),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_idx),
        .rdata (ram_rdata)
    );

    // The RAM returns the old contents when a word reads the entry that the
    // previous word writes in the same cycle, so the last write is kept here.
    logic                  fwd_valid_reg;
    logic [CELL_IDX_W-1:0] fwd_idx_reg;
    logic [ENTRY_W-1:0]    fwd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_valid_reg <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else if (ram_we)
        begin
            cnt_valid_reg[s1_idx_reg] <= 1'b1;
            fwd_valid_reg             <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            fwd_idx_reg  <= s1_idx_reg;
            fwd_data_reg <= ram_wdata;
        end
    end

    logic [ENTRY_W-1:0] cur_entry;

    always_comb
    begin
        if (fwd_valid_reg && (fwd_idx_reg == s1_idx_reg))
        begin
            cur_entry = fwd_data_reg;
        end
        else if (cnt_valid_reg[s1_idx_reg])
        begin
            cur_entry = ram_rdata;
        end
        else
        begin
            cur_entry = '0;
        end
    end

    // ---------------------------------------------------------------
    // Checks. Voltage goes first; a voltage fault leaves the temperature
    // counter as it was. A halted scan skips every cell until its end.
    // ---------------------------------------------------------------
    logic         scan_halted_reg;
    logic         vbad;
    logic         tbad;
    bump_t        vstep;
    bump_t        tstep;
    logic         do_update;
    logic         halted_after;
    cell_status_t status_next;

    assign vbad = (s1_voltage_reg >= cfg.voltage_high_limit) ||
                  (s1_voltage_reg <= cfg.voltage_low_limit) || s1_vlink_reg;
    assign tbad = (s1_temp_reg >= cfg.temp_high_limit) ||
                  (s1_temp_reg <= cfg.temp_low_limit) || s1_tlink_reg;

    assign vstep = bump(cur_entry[ENTRY_W-1:CNT_W], vbad, cfg.voltage_fault_count);
    assign tstep = bump(cur_entry[CNT_W-1:0], tbad, cfg.temp_fault_count);

    assign do_update = !scan_halted_reg && s1_in_range_reg;
    assign ram_we    = s1_fire && do_update;

    always_comb
    begin
        ram_wdata    = {vstep.cnt, cur_entry[CNT_W-1:0]};
        status_next  = STATUS_OK;
        halted_after = scan_halted_reg;
        if (scan_halted_reg)
        begin
            status_next = STATUS_SKIPPED;
        end
        else if (s1_in_range_reg)
        begin
            if (vstep.fault)
            begin
                status_next  = STATUS_VOLT_FAULT;
                halted_after = 1'b1;
            end
            else
            begin
                ram_wdata = {vstep.cnt, tstep.cnt};
                if (tstep.fault)
                begin
                    status_next  = STATUS_TEMP_FAULT;
                    halted_after = 1'b1;
                end
            end
        end
    end

    // The end of a scan reports whether it halted and opens the next one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_halted_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            scan_halted_reg <= halted_after && !s1_last_reg;
        end
    end

    // ---------------------------------------------------------------
    // Result register: holds a finished word while the next is checked.
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_status_reg     <= status_next;
            out_scan_fault_reg <= s1_last_reg && halted_after;
        end
    end

    assign status.valid       = out_valid_reg;
    assign status.cell_status = out_status_reg;
    assign status.scan_fault  = out_scan_fault_reg;

endmodule

@@ rtl/cfm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/cfm_cfg_regs.sv @@
// APB-style configuration registers for limits and fault counts.
`timescale 1ns / 1ps

module cfm_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cfm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [cfm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [cfm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output cfm_pkg::cfg_t                     cfg
);
    import cfm_pkg::*;

    cfg_t                 cfg_reg;
    logic [REG_SEL_W-1:0] reg_sel;
    logic                 wr_en;

    // Low two address bits select a byte within a word and are ignored.
    assign reg_sel = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.voltage_low_limit   <= RST_VOLTAGE_LOW_LIMIT;
            cfg_reg.voltage_high_limit  <= RST_VOLTAGE_HIGH_LIMIT;
            cfg_reg.temp_low_limit      <= RST_TEMP_LOW_LIMIT;
            cfg_reg.temp_high_limit     <= RST_TEMP_HIGH_LIMIT;
            cfg_reg.voltage_fault_count <= RST_VOLTAGE_FAULT_COUNT;
            cfg_reg.temp_fault_count    <= RST_TEMP_FAULT_COUNT;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_VOLTAGE_LOW_LIMIT:   cfg_reg.voltage_low_limit   <= pwdata[VOLT_W-1:0];
                REG_VOLTAGE_HIGH_LIMIT:  cfg_reg.voltage_high_limit  <= pwdata[VOLT_W-1:0];
                REG_TEMP_LOW_LIMIT:      cfg_reg.temp_low_limit      <= pwdata[TEMP_W-1:0];
                REG_TEMP_HIGH_LIMIT:     cfg_reg.temp_high_limit     <= pwdata[TEMP_W-1:0];
                REG_VOLTAGE_FAULT_COUNT: cfg_reg.voltage_fault_count <= pwdata[CNT_W-1:0];
                REG_TEMP_FAULT_COUNT:    cfg_reg.temp_fault_count    <= pwdata[CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_sel)
            REG_VOLTAGE_LOW_LIMIT:   prdata[VOLT_W-1:0] = cfg_reg.voltage_low_limit;
            REG_VOLTAGE_HIGH_LIMIT:  prdata[VOLT_W-1:0] = cfg_reg.voltage_high_limit;
            REG_TEMP_LOW_LIMIT:      prdata[TEMP_W-1:0] = cfg_reg.temp_low_limit;
            REG_TEMP_HIGH_LIMIT:     prdata[TEMP_W-1:0] = cfg_reg.temp_high_limit;
            REG_VOLTAGE_FAULT_COUNT: prdata[CNT_W-1:0]  = cfg_reg.voltage_fault_count;
            REG_TEMP_FAULT_COUNT:    prdata[CNT_W-1:0]  = cfg_reg.temp_fault_count;
            default:                 prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule
